/* design/fp12c_pkg.sv */
// Shared types and constants of the fp12 format converter.
package fp12c_pkg;

	localparam int unsigned FP12_BIAS   = 31;
	localparam int unsigned SINGLE_BIAS = 127;
	localparam int unsigned FRAC_BITS   = 5;
	localparam int unsigned EXP_BITS    = 6;

	// fp12 field layout inside the 16-bit container
	localparam int unsigned FP12_SIGN_BIT = 15;
	localparam int unsigned FILL_BITS     = 16 - FRAC_BITS - EXP_BITS;

	// exponent codes
	localparam logic [EXP_BITS-1:0] EXP_SPECIAL = '1;
	// first biased exponent whose integer value no longer fits in 32 bits
	localparam logic [EXP_BITS-1:0] EXP_INT_OVF = EXP_BITS'(FP12_BIAS + 31);

	localparam logic [31:0] INT_INVALID = 32'h8000_0000;

	// single exponent offsets
	localparam logic [7:0] SGL_NORM_OFS   = 8'(SINGLE_BIAS - FP12_BIAS);
	localparam logic [7:0] SGL_DENORM_OFS = 8'(SINGLE_BIAS - FP12_BIAS - (FRAC_BITS - 1));
	localparam logic [7:0] SGL_EXP_SPECIAL = '1;

	typedef enum logic [1:0] {
		OP_INT_TO_FP12    = 2'd0,
		OP_FP12_TO_INT    = 2'd1,
		OP_FP12_TO_SINGLE = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] int_value;
		logic [15:0]        fp12_value;
	} cvt_req_t;

	typedef struct packed {
		logic [15:0]        fp12_result;
		logic signed [31:0] int_result;
		logic [31:0]        float_bits;
	} cvt_rsp_t;

endpackage

/* design/fp12c_in_if.sv */
// Input channel of the fp12 converter: valid/ready plus operand payload.
interface fp12c_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] int_value;
	logic [15:0]        fp12_value;

	modport source (output valid, operation, int_value, fp12_value, input ready);
	modport sink (input valid, operation, int_value, fp12_value, output ready);
endinterface

/* design/fp12c_out_if.sv */
// Output channel of the fp12 converter: valid/ready plus result payload.
interface fp12c_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        fp12_result;
	logic signed [31:0] int_result;
	logic [31:0]        float_bits;

	modport source (output valid, fp12_result, int_result, float_bits, input ready);
	modport sink (input valid, fp12_result, int_result, float_bits, output ready);
endinterface

/* design/fp12c_convert.sv */
// Conversion datapath: int to fp12, fp12 to int, fp12 to single.
module fp12c_convert (
	input  fp12c_pkg::cvt_req_t req,
	output fp12c_pkg::cvt_rsp_t rsp
);
	import fp12c_pkg::*;

	// index of highest set bit; 0 when none
	function automatic logic [4:0] lead_one32(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) r = 5'(i);
		end
		return r;
	endfunction

	function automatic logic [2:0] lead_one5(input logic [4:0] v);
		logic [2:0] r;
		r = '0;
		for (int i = 0; i < 5; i++) begin
			if (v[i]) r = 3'(i);
		end
		return r;
	endfunction

	// int to fp12
	logic               i_neg;
	logic [31:0]        i_mag;
	logic [4:0]         i_lead;
	logic [31:0]        i_norm;
	logic               i_guard;
	logic               i_sticky;
	logic [EXP_BITS-1:0] i_exp;
	logic [10:0]        i_base;
	logic [10:0]        i_sum;
	logic [15:0]        i_res;

	// fp12 fields
	logic                 f_neg;
	logic [EXP_BITS-1:0]  f_exp;
	logic [FRAC_BITS-1:0] f_frac;

	// fp12 to int
	logic [EXP_BITS-1:0] t_ue;
	logic [36:0]         t_wide;
	logic [31:0]         t_mag;
	logic [31:0]         t_res;

	// fp12 to single
	logic [2:0]  s_lead;
	logic [4:0]  s_norm;
	logic [31:0] s_res;

	always_comb begin
		i_neg    = req.int_value[31];
		i_mag    = i_neg ? (32'd0 - req.int_value) : req.int_value;
		i_lead   = lead_one32(i_mag);
		i_norm   = i_mag << (5'd31 - i_lead);
		i_guard  = i_norm[25];
		i_sticky = |i_norm[24:0];
		i_exp    = EXP_BITS'(FP12_BIAS) + {1'b0, i_lead};
		i_base   = {i_exp, i_norm[30:26]};
		// round to nearest even; carry ripples into the exponent
		i_sum    = i_base + 11'(i_guard & (i_sticky | i_norm[26]));
		if (i_mag == '0) begin
			i_res = '0;
		end else begin
			i_res = {{FILL_BITS{i_neg}}, i_sum};
		end
	end

	always_comb begin
		f_neg  = req.fp12_value[FP12_SIGN_BIT];
		f_exp  = req.fp12_value[FRAC_BITS +: EXP_BITS];
		f_frac = req.fp12_value[FRAC_BITS-1:0];

		t_ue   = f_exp - EXP_BITS'(FP12_BIAS);
		t_wide = {31'd0, 1'b1, f_frac} << t_ue;
		t_mag  = t_wide[36:5];
		if (f_exp >= EXP_INT_OVF) begin
			t_res = INT_INVALID;
		end else if (f_exp < EXP_BITS'(FP12_BIAS)) begin
			t_res = '0;
		end else begin
			t_res = f_neg ? (32'd0 - t_mag) : t_mag;
		end

		s_lead = lead_one5(f_frac);
		s_norm = f_frac << (3'd4 - s_lead);
		if (f_exp == EXP_SPECIAL) begin
			s_res = {f_neg, SGL_EXP_SPECIAL, f_frac, 18'd0};
		end else if (f_exp != '0) begin
			s_res = {f_neg, 8'(f_exp) + SGL_NORM_OFS, f_frac, 18'd0};
		end else if (f_frac == '0) begin
			s_res = {f_neg, 31'd0};
		end else begin
			s_res = {f_neg, 8'(s_lead) + SGL_DENORM_OFS, s_norm[3:0], 19'd0};
		end
	end

	always_comb begin
		rsp = '0;
		case (req.operation)
			OP_INT_TO_FP12:    rsp.fp12_result = i_res;
			OP_FP12_TO_INT:    rsp.int_result  = t_res;
			OP_FP12_TO_SINGLE: rsp.float_bits  = s_res;
			default:           rsp = '0;
		endcase
	end

endmodule

/* design/fp12_format_converter_core.sv */
// Top level of the fp12 format converter: operand register, converter, result register.
//
// Converts between 32-bit signed integers, the 12-bit minifloat fp12 (sign,
// 6-bit exponent with bias 31, 5-bit fraction, held in 16 bits with the sign
// copied into bits 11..15) and IEEE single bit patterns. operation selects
// int to fp12 (round to nearest even, zero stays 0x0000), fp12 to int
// (truncate toward zero, 0x80000000 when out of range, infinity or NaN) or
// fp12 to single (exact, denormals normalized). Only the selected result
// field can be nonzero; the unused operation code returns all zeros. Bit 15 of
// fp12_value is the sign, bits 11..14 are ignored. Each transfer on cmd
// yields exactly one transfer on rsp, in order. The block is a two-register
// pipeline: an operand register and a result register with the conversion
// logic (32-bit leading-one search, normalizing shift and rounding add) between
// them. The operand register takes each cmd transfer and the result register its
// conversion. Throughput is one transfer per cycle as long as rsp.ready stays
// high. Back-pressure stalls both stages in place without losing data.
module fp12_format_converter_core (
	input  logic                clk,
	input  logic                arst_n,
	fp12c_in_if.sink            cmd,
	fp12c_out_if.source         rsp
);
	import fp12c_pkg::*;

	// stage 1: operand register
	logic     valid_s1;
	cvt_req_t req_s1;
	// stage 2: result register
	logic     valid_s2;
	cvt_rsp_t rsp_s2;

	cvt_rsp_t cvt_rsp;
	logic     adv_s2;
	logic     adv_s1;

	// result register frees up when empty or its transfer completes
	assign adv_s2    = !valid_s2 || rsp.ready;
	// operand register frees up when empty or it moves forward
	assign adv_s1    = !valid_s1 || adv_s2;
	assign cmd.ready = adv_s1;

	fp12c_convert u_convert (
		.req (req_s1),
		.rsp (cvt_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= cmd.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (adv_s1 && cmd.valid) begin
			req_s1.operation  <= cmd.operation;
			req_s1.int_value  <= cmd.int_value;
			req_s1.fp12_value <= cmd.fp12_value;
		end
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= cvt_rsp;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.fp12_result = rsp_s2.fp12_result;
	assign rsp.int_result  = rsp_s2.int_result;
	assign rsp.float_bits  = rsp_s2.float_bits;

	// an accepted operand always lands in stage 1
	a_cmd_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> valid_s1)
		else $error("accepted operand missing from stage 1");

	// stage 1 moving forward always produces a result
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> rsp.valid)
		else $error("stage 1 item lost before result register");

	// a blocked stage 1 keeps its operand
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(req_s1))
		else $error("stage 1 operand changed while stalled");

	// at most one result field is nonzero
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $countones({rsp.fp12_result != '0, rsp.int_result != '0,
			rsp.float_bits != '0}) <= 1)
		else $error("more than one result field set");

endmodule

/* test/fp12_format_converter_core_tb.sv */
// Self-checking testbench for the fp12 format converter: directed table plus random transfers.
module fp12_format_converter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fp12c_pkg::*;

	// Operation code 3 has no enum member; the block must answer it with all zeros.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;     // two-stage pipeline, plenty of slack
	localparam int IDLE_PCT     = 21;
	localparam int STEADY_FROM  = 600;    // no idling on either side in this window
	localparam int STEADY_TO    = 900;
	localparam int HOLD_CYCLES  = 80;     // long output stall, counted by the receiver
	localparam int HOLD_AT_A    = 300;
	localparam int HOLD_AT_B    = 1100;

	// One row of the directed table. When fixed is set, result holds the answer typed in
	// by hand; otherwise the answer comes from the predictor below.
	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] int_value;
		logic [15:0] fp12_value;
		logic        fixed;
		cvt_rsp_t    result;
	} probe_t;

	localparam cvt_rsp_t NO_RSP = '0;
	localparam int N_PROBES = 27;

	localparam probe_t PROBES [N_PROBES] = '{
		// int to fp12: zero, +-1, both integer extremes, rounding ties and carry
		'{OP_INT_TO_FP12, 32'h0000_0000, 16'h0000, 1'b1, '{16'h0000, 32'h0, 32'h0}},
		'{OP_INT_TO_FP12, 32'h0000_0001, 16'hFFFF, 1'b1, '{16'h03E0, 32'h0, 32'h0}},
		'{OP_INT_TO_FP12, 32'hFFFF_FFFF, 16'h0000, 1'b1, '{16'hFBE0, 32'h0, 32'h0}},
		'{OP_INT_TO_FP12, 32'h7FFF_FFFF, 16'h0000, 1'b1, '{16'h07C0, 32'h0, 32'h0}},
		'{OP_INT_TO_FP12, 32'h8000_0000, 16'h0000, 1'b1, '{16'hFFC0, 32'h0, 32'h0}},
		'{OP_INT_TO_FP12, 32'd65,        16'h0000, 1'b0, NO_RSP},   // tie, kept even
		'{OP_INT_TO_FP12, 32'd67,        16'h0000, 1'b0, NO_RSP},   // tie, rounded up to even
		'{OP_INT_TO_FP12, 32'd127,       16'h0000, 1'b0, NO_RSP},   // carry into exponent
		'{OP_INT_TO_FP12, -32'sd100,     16'h0000, 1'b0, NO_RSP},
		// fp12 to int: zero, +-1, below one, overflow exponent, inf, NaN, largest in range
		'{OP_FP12_TO_INT, 32'h0, 16'h0000, 1'b1, '{16'h0, 32'h0000_0000, 32'h0}},
		'{OP_FP12_TO_INT, 32'hFFFF_FFFF, 16'h03E0, 1'b1, '{16'h0, 32'h0000_0001, 32'h0}},
		'{OP_FP12_TO_INT, 32'h0, 16'hFBE0, 1'b1, '{16'h0, 32'hFFFF_FFFF, 32'h0}},
		'{OP_FP12_TO_INT, 32'h0, 16'h03DF, 1'b1, '{16'h0, 32'h0000_0000, 32'h0}},
		'{OP_FP12_TO_INT, 32'h0, 16'h07C0, 1'b1, '{16'h0, INT_INVALID, 32'h0}},
		'{OP_FP12_TO_INT, 32'h0, 16'h07E0, 1'b1, '{16'h0, INT_INVALID, 32'h0}},
		'{OP_FP12_TO_INT, 32'h0, 16'hFFE1, 1'b1, '{16'h0, INT_INVALID, 32'h0}},
		'{OP_FP12_TO_INT, 32'h0, 16'h07BF, 1'b0, NO_RSP},
		'{OP_FP12_TO_INT, 32'h0, 16'hFFBF, 1'b0, NO_RSP},
		// only bit 15 carries the sign, bits 14..11 are don't-care
		'{OP_FP12_TO_INT, 32'h0, 16'h83E0, 1'b1, '{16'h0, 32'hFFFF_FFFF, 32'h0}},
		'{OP_FP12_TO_INT, 32'h0, 16'h7BE0, 1'b1, '{16'h0, 32'h0000_0001, 32'h0}},
		// fp12 to single: signed zero, inf, NaN, one, smallest and largest denormal
		'{OP_FP12_TO_SINGLE, 32'h0, 16'h8000, 1'b1, '{16'h0, 32'h0, 32'h8000_0000}},
		'{OP_FP12_TO_SINGLE, 32'h0, 16'h07E0, 1'b1, '{16'h0, 32'h0, 32'h7F80_0000}},
		'{OP_FP12_TO_SINGLE, 32'h0, 16'hFFFF, 1'b0, NO_RSP},
		'{OP_FP12_TO_SINGLE, 32'h0, 16'h03E0, 1'b1, '{16'h0, 32'h0, 32'h3F80_0000}},
		'{OP_FP12_TO_SINGLE, 32'h0, 16'h0001, 1'b0, NO_RSP},
		'{OP_FP12_TO_SINGLE, 32'h0, 16'h001F, 1'b0, NO_RSP},
		// unused code with every operand bit set
		'{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, '{16'h0, 32'h0, 32'h0}}
	};

	logic clk;
	logic arst_n;

	fp12c_in_if  cmd_ch ();
	fp12c_out_if rsp_ch ();

	fp12_format_converter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Conversions accepted on cmd whose answers have not yet come back on rsp, oldest first.
	cvt_rsp_t conversions_due [$];

	int sent;           // transfers accepted on cmd
	int checked;        // transfers compared on rsp
	int faults;         // mismatches, unexpected results
	int cycles;
	int op_seen [4];

	// ---------------------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------------------

	// Signed integer to fp12, round to nearest even on the bits below the 5-bit fraction.
	function automatic logic [15:0] int_to_fp12(logic [31:0] n);
		logic        neg;
		logic [31:0] mag;
		logic [31:0] kept;
		logic [31:0] acc;
		logic        guard;
		logic        sticky;
		int          p;
		int          s;
		neg = n[31];
		mag = neg ? -n : n;
		if (mag == 0) begin
			return '0;   // zero has no sign fill
		end
		p = 31;
		while (!mag[p]) p--;
		acc = (FP12_BIAS + p) << FRAC_BITS;
		if (p <= FRAC_BITS) begin
			acc = acc + ((mag << (FRAC_BITS - p)) & 32'd31);
		end else begin
			s      = p - FRAC_BITS;
			kept   = mag >> s;
			guard  = mag[s-1];
			sticky = (mag & ((32'd1 << (s - 1)) - 32'd1)) != 0;
			// a carry out of the fraction bumps the exponent field on its own
			acc = acc + (kept & 32'd31);
			if (guard && (sticky || kept[0])) acc = acc + 32'd1;
		end
		if (neg) acc[FP12_SIGN_BIT -: FILL_BITS] = '1;
		return acc[15:0];
	endfunction

	// fp12 to signed integer, truncating toward zero.
	function automatic logic [31:0] fp12_to_int(logic [15:0] x);
		logic [EXP_BITS-1:0] e;
		logic [31:0]         sig;
		logic [31:0]         mag;
		int                  ue;
		e   = x[FRAC_BITS +: EXP_BITS];
		sig = {26'd0, 1'b1, x[FRAC_BITS-1:0]};
		if (e == EXP_SPECIAL || e >= EXP_BITS'(FP12_BIAS + 31)) begin
			return INT_INVALID;
		end
		if (e < FP12_BIAS) begin
			return '0;
		end
		ue  = int'(e) - int'(FP12_BIAS);
		mag = (ue >= FRAC_BITS) ? (sig << (ue - FRAC_BITS)) : (sig >> (FRAC_BITS - ue));
		return x[FP12_SIGN_BIT] ? -mag : mag;
	endfunction

	// fp12 to IEEE single; exact, denormals renormalized.
	function automatic logic [31:0] fp12_to_single(logic [15:0] x);
		logic                 sign;
		logic [EXP_BITS-1:0]  e;
		logic [FRAC_BITS-1:0] frac;
		logic [31:0]          mant;
		int                   q;
		sign = x[FP12_SIGN_BIT];
		e    = x[FRAC_BITS +: EXP_BITS];
		frac = x[FRAC_BITS-1:0];
		if (e == EXP_SPECIAL) begin
			return {sign, 8'hFF, frac, 18'd0};
		end
		if (e != 0) begin
			return {sign, 8'(int'(e) + int'(SINGLE_BIAS) - int'(FP12_BIAS)), frac, 18'd0};
		end
		if (frac == 0) begin
			return {sign, 31'd0};
		end
		q = FRAC_BITS - 1;
		while (!frac[q]) q--;
		// denormal value is frac * 2^-(bias + fraction bits - 1)
		mant = 32'(frac) << (23 - q);
		return {sign, 8'(q + int'(SINGLE_BIAS) - int'(FP12_BIAS + FRAC_BITS - 1)), mant[22:0]};
	endfunction

	function automatic cvt_rsp_t convert_operand(cvt_req_t r);
		cvt_rsp_t o;
		o = '0;
		case (r.operation)
			OP_INT_TO_FP12:    o.fp12_result = int_to_fp12(r.int_value);
			OP_FP12_TO_INT:    o.int_result  = fp12_to_int(r.fp12_value);
			OP_FP12_TO_SINGLE: o.float_bits  = fp12_to_single(r.fp12_value);
			default:           o = '0;
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------------------------
	// Random operands
	// ---------------------------------------------------------------------------------

	// Integer operands aimed at the leading-one search and the rounding corner cases.
	function automatic logic [31:0] random_int_operand();
		logic [31:0] mag;
		int          p;
		int          s;
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: begin
				p   = $urandom_range(0, 31);
				mag = (32'd1 << p) | ($urandom() & ((32'd1 << p) - 32'd1));
			end
			2: begin
				// exact tie, sometimes broken by a sticky bit
				p   = $urandom_range(6, 31);
				s   = p - FRAC_BITS;
				mag = ((32'd32 | 32'($urandom_range(0, 31))) << s) | (32'd1 << (s - 1));
				if ($urandom_range(0, 1)) mag = mag | ($urandom() & ((32'd1 << (s - 1)) - 32'd1));
			end
			3: mag = $urandom_range(0, 64);
			default: begin
				// all-ones fraction, so rounding up carries into the exponent
				p   = $urandom_range(6, 31);
				s   = p - FRAC_BITS;
				mag = (32'd63 << s) | ($urandom() & ((32'd1 << s) - 32'd1));
			end
		endcase
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// Mostly well-formed fp12 (fill bits equal to the sign), exponents near the
	// interesting boundaries; the rest is raw noise in all 16 bits.
	function automatic logic [15:0] random_fp12_operand();
		logic                 sign;
		logic [EXP_BITS-1:0]  e;
		logic [FRAC_BITS-1:0] frac;
		if ($urandom_range(0, 99) < 15) begin
			return 16'($urandom());
		end
		sign = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: e = EXP_BITS'($urandom_range(0, 63));
			1: e = EXP_BITS'($urandom_range(29, 36));
			2: e = EXP_BITS'($urandom_range(58, 63));
			default: e = EXP_BITS'($urandom_range(0, 2));
		endcase
		frac = FRAC_BITS'($urandom_range(0, 31));
		return {{FILL_BITS{sign}}, e, frac};
	endfunction

	function automatic cvt_req_t random_request();
		cvt_req_t r;
		int       pick;
		pick = $urandom_range(0, 99);
		if (pick < 30) r.operation = OP_INT_TO_FP12;
		else if (pick < 60) r.operation = OP_FP12_TO_INT;
		else if (pick < 92) r.operation = OP_FP12_TO_SINGLE;
		else r.operation = OP_UNUSED;
		// the operand the operation does not use is randomized too
		r.int_value  = random_int_operand();
		r.fp12_value = random_fp12_operand();
		return r;
	endfunction

	function automatic bit steady_window();
		return sent >= STEADY_FROM && sent < STEADY_TO;
	endfunction

	// ---------------------------------------------------------------------------------
	// Clock and reset
	// ---------------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------------------
	// cmd side
	// ---------------------------------------------------------------------------------

	// Offers one conversion and returns at the edge where it is accepted. Random idle
	// cycles go in front of it outside the steady window. Callers set valid for the next
	// cycle in that same step, so valid only ever gets one nonblocking write per edge.
	task automatic offer_conversion(cvt_req_t r, cvt_rsp_t answer);
		while (!steady_window() && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.operation  <= r.operation;
		cmd_ch.int_value  <= r.int_value;
		cmd_ch.fp12_value <= r.fp12_value;
		@(posedge clk);
		// values read right after the edge are those the DUT sampled at it
		while (!cmd_ch.ready) @(posedge clk);
		conversions_due.push_back(answer);
		op_seen[r.operation]++;
		sent++;
	endtask

	initial begin
		cvt_req_t r;
		cvt_rsp_t answer;

		cmd_ch.valid      = 1'b0;
		cmd_ch.operation  = '0;
		cmd_ch.int_value  = '0;
		cmd_ch.fp12_value = '0;
		sent    = 0;
		checked = 0;
		faults  = 0;
		op_seen = '{default: 0};

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: hand-typed answers where obvious, predictor elsewhere.
		for (int i = 0; i < N_PROBES; i++) begin
			r.operation  = PROBES[i].operation;
			r.int_value  = PROBES[i].int_value;
			r.fp12_value = PROBES[i].fp12_value;
			answer = PROBES[i].fixed ? PROBES[i].result : convert_operand(r);
			offer_conversion(r, answer);
		end

		// Random traffic.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r = random_request();
			offer_conversion(r, convert_operand(r));
		end
		cmd_ch.valid <= 1'b0;

		// Drain: every answer back, then a few idle cycles to catch strays.
		while (conversions_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d conversions: %0d int->fp12, %0d fp12->int, %0d fp12->single,",
			sent, op_seen[OP_INT_TO_FP12], op_seen[OP_FP12_TO_INT], op_seen[OP_FP12_TO_SINGLE]);
		$display("%0d unused-code; %0d results checked, random idling and two long rsp stalls.",
			op_seen[OP_UNUSED], checked);
		if (faults == 0 && conversions_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d failures, %0d results missing", faults, conversions_due.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// rsp side: random ready, a steady window, and two long hold-offs that let the
	// pipeline fill so cmd.ready must drop while the sender keeps offering.
	// ---------------------------------------------------------------------------------

	initial begin
		int hold;
		int holds_done;
		hold       = 0;
		holds_done = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if ((holds_done == 0 && sent >= HOLD_AT_A) || (holds_done == 1 && sent >= HOLD_AT_B)) begin
				holds_done++;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else if (steady_window()) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Result checking
	// ---------------------------------------------------------------------------------

	task automatic note_fault(string msg);
		faults++;
		if (faults <= 10) $display("[%0t] %s", $realtime, msg);
	endtask

	task automatic check_result(cvt_rsp_t got);
		cvt_rsp_t want;
		if (conversions_due.size() == 0) begin
			note_fault($sformatf("unexpected transfer: fp12 %h int %h float %h",
				got.fp12_result, got.int_result, got.float_bits));
			return;
		end
		want = conversions_due.pop_front();
		checked++;
		if (got.fp12_result !== want.fp12_result || got.int_result !== want.int_result ||
				got.float_bits !== want.float_bits) begin
			note_fault($sformatf("result %0d: fp12 %h/%h int %h/%h float %h/%h (want/got)",
				checked, want.fp12_result, got.fp12_result, want.int_result, got.int_result,
				want.float_bits, got.float_bits));
		end
	endtask

	initial begin
		cvt_rsp_t got;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
				got.fp12_result = rsp_ch.fp12_result;
				got.int_result  = rsp_ch.int_result;
				got.float_bits  = rsp_ch.float_bits;
				check_result(got);
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d accepted, %0d checked", cycles, sent, checked);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* fp12_format_converter_core.f */
design/fp12c_pkg.sv
design/fp12c_in_if.sv
design/fp12c_out_if.sv
design/fp12c_convert.sv
design/fp12_format_converter_core.sv
test/fp12_format_converter_core_tb.sv
